FILE: rtl/huffman_code_builder_macros.svh
// ----------------------------------------------------------------------------
// huffman code builder assertion macros
// concurrent assertion shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BUILDER_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_MACROS_SVH

// same-cycle implication
`define HCB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// shared constants and codes of the huffman code builder
// ----------------------------------------------------------------------------
package hcb_pkg;

	localparam int MAX_SYMBOLS  = 256;
	localparam int MAX_CODE_LEN = 64;
	localparam int NODE_DEPTH   = 2 * MAX_SYMBOLS - 1;
	localparam int STACK_DEPTH  = 2 * MAX_SYMBOLS;

	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;
	localparam int SYM_W  = 8;
	localparam int FREQ_W = 24;
	localparam int WGT_W  = 32;
	localparam int CODE_W = 64;
	localparam int LEN_W  = 7;

	localparam int SYM_COUNT = 1 << SYM_W;
	localparam int SLOT_AW   = $clog2(MAX_SYMBOLS);
	localparam int CNT_W     = $clog2(MAX_SYMBOLS + 1);
	localparam int NODE_AW   = $clog2(NODE_DEPTH);
	localparam int STACK_AW  = $clog2(STACK_DEPTH);
	localparam int STACK_W   = NODE_AW + LEN_W + CODE_W;
	localparam int CTAB_W    = LEN_W + CODE_W;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_BUILD  = 2'd1,
		FUNC_LOOKUP = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_READY = 2'd3
	} status_t;

endpackage

FILE: rtl/hcb_in_if.sv
// ----------------------------------------------------------------------------
// hcb_in_if
// command channel: function, symbol and frequency
// ----------------------------------------------------------------------------
interface hcb_in_if import hcb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [SYM_W-1:0]  symbol;
	logic [FREQ_W-1:0] frequency;

	modport source (output valid, func, symbol, frequency, input ready);
	modport sink (input valid, func, symbol, frequency, output ready);
endinterface

FILE: rtl/hcb_out_if.sv
// ----------------------------------------------------------------------------
// hcb_out_if
// response channel: status, code word and code length
// ----------------------------------------------------------------------------
interface hcb_out_if import hcb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [CODE_W-1:0] code_word;
	logic [LEN_W-1:0]  code_len;

	modport source (output valid, status, code_word, code_len, input ready);
	modport sink (input valid, status, code_word, code_len, output ready);
endinterface

FILE: rtl/huffman_code_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_builder
// loads leaves, builds huffman codes on a min-heap in memory, looks up, clears
//
// channel  dir  payload
// cmd      in   func, symbol, frequency
// rsp      out  status, code_word, code_len
//
// load, clear and error answers pass exec and answer states, a lookup also
// a code read state, plus output wait. build runs on the heap memory, one
// read or write step per cycle; each sift level reads, compares and moves.
// reset clears control and code valid bits at once, no memory sweep.
// a stalled response holds the block in its answer state; one word at a time.
// ----------------------------------------------------------------------------
module huffman_code_builder import hcb_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	hcb_in_if.sink    cmd,
	hcb_out_if.source rsp
);
	typedef enum logic [25:0] {
		S_IDLE = 26'b1 << 0,
		S_EXEC = 26'b1 << 1,
		S_LKW  = 26'b1 << 2,
		S_RESP = 26'b1 << 3,
		S_FILL = 26'b1 << 4,
		S_HP0  = 26'b1 << 5,
		S_HP1  = 26'b1 << 6,
		S_SDW  = 26'b1 << 7,
		S_SDR  = 26'b1 << 8,
		S_SDC  = 26'b1 << 9,
		S_SDM  = 26'b1 << 10,
		S_MCHK = 26'b1 << 11,
		S_TK0  = 26'b1 << 12,
		S_TK1  = 26'b1 << 13,
		S_MG0  = 26'b1 << 14,
		S_MG1  = 26'b1 << 15,
		S_PU0  = 26'b1 << 16,
		S_PU1  = 26'b1 << 17,
		S_PU2  = 26'b1 << 18,
		S_RT0  = 26'b1 << 19,
		S_RT1  = 26'b1 << 20,
		S_W0   = 26'b1 << 21,
		S_W1   = 26'b1 << 22,
		S_W2   = 26'b1 << 23,
		S_W3   = 26'b1 << 24,
		S_W4   = 26'b1 << 25
	} state_t;

	typedef enum logic [1:0] {
		RET_HPY = 2'd0,
		RET_TA  = 2'd1,
		RET_TB  = 2'd2
	} sd_ret_t;

	state_t                state_q;
	sd_ret_t               ret_q;
	func_t                 func_q;
	logic [SYM_W-1:0]      sym_q;
	logic [FREQ_W-1:0]     freq_q;
	status_t               res_stat_q;
	logic [CODE_W-1:0]     res_word_q;
	logic [LEN_W-1:0]      res_len_q;
	logic                  ovalid_q;
	logic [STAT_W-1:0]     ostat_q;
	logic [CODE_W-1:0]     oword_q;
	logic [LEN_W-1:0]      olen_q;
	logic [CNT_W-1:0]      lc_q;
	logic                  tr_q;
	logic [SYM_COUNT-1:0]  valid_q;
	logic [CNT_W-1:0]      hs_q;
	logic [SLOT_AW-1:0]    i_q;
	logic [SLOT_AW-1:0]    hi_q;
	logic [NODE_AW-1:0]    node_i_q;
	logic [WGT_W-1:0]      wi_q;
	logic [NODE_AW-1:0]    sl_q;
	logic [NODE_AW-1:0]    sr_q;
	logic [NODE_AW-1:0]    a_q;
	logic [NODE_AW-1:0]    b_q;
	logic                  take_b_q;
	logic [NODE_AW-1:0]    nxt_q;
	logic [WGT_W-1:0]      wn_q;
	logic [NODE_AW-1:0]    ps_q;
	logic [STACK_AW-1:0]   sp_q;
	logic [LEN_W-1:0]      e_len_q;
	logic [CODE_W-1:0]     e_code_q;
	logic [NODE_AW-1:0]    lchild_q;

	logic                  leaf_we;
	logic [SLOT_AW-1:0]    leaf_wa, leaf_ra;
	logic [SYM_W-1:0]      leaf_wd, leaf_rd;
	logic                  wt_we;
	logic [NODE_AW-1:0]    wt_wa, wt_ra0, wt_ra1;
	logic [WGT_W-1:0]      wt_wd, w_rd0, w_rd1;
	logic                  ch_we;
	logic [NODE_AW-1:0]    ch_wa, ch_ra;
	logic [2*NODE_AW-1:0]  ch_wd, ch_rd;
	logic                  heap_we;
	logic [SLOT_AW-1:0]    heap_wa, heap_ra0, heap_ra1;
	logic [NODE_AW-1:0]    heap_wd, heap_rd0, heap_rd1;
	logic                  code_we;
	logic [SYM_W-1:0]      code_wa, code_ra;
	logic [CTAB_W-1:0]     code_wd, code_rd;
	logic                  stk_we;
	logic [STACK_AW-1:0]   stk_wa, stk_ra;
	logic [STACK_W-1:0]    stk_wd, stk_rd;

	logic [SLOT_AW+1:0]    l_idx, r_idx;
	logic                  l_ok, r_ok, take_l, take_r, sd_move;
	logic [WGT_W-1:0]      w_small, w_sum;
	logic [SLOT_AW-1:0]    sd_dst, parent, hi_start;
	logic [NODE_AW-1:0]    sd_node, stk_node;
	logic [CNT_W-1:0]      hs_m1, lc_m2;
	logic                  lc_full;
	logic [LEN_W-1:0]      nl;
	logic [CODE_W-1:0]     c0, c1;

	assign cmd.ready     = (state_q == S_IDLE);
	assign rsp.valid     = ovalid_q;
	assign rsp.status    = ostat_q;
	assign rsp.code_word = oword_q;
	assign rsp.code_len  = olen_q;

	assign l_idx    = {1'b0, i_q, 1'b1};
	assign r_idx    = l_idx + (SLOT_AW+2)'(1);
	assign l_ok     = l_idx < (SLOT_AW+2)'(hs_q);
	assign r_ok     = r_idx < (SLOT_AW+2)'(hs_q);
	assign take_l   = l_ok && (w_rd0 < wi_q);
	assign w_small  = take_l ? w_rd0 : wi_q;
	assign take_r   = r_ok && (w_rd1 < w_small);
	assign sd_move  = take_l || take_r;
	assign sd_dst   = take_r ? r_idx[SLOT_AW-1:0] : l_idx[SLOT_AW-1:0];
	assign sd_node  = take_r ? sr_q : sl_q;
	assign parent   = (i_q - SLOT_AW'(1)) >> 1;
	assign hs_m1    = hs_q - CNT_W'(1);
	assign lc_m2    = lc_q - CNT_W'(2);
	assign hi_start = SLOT_AW'(lc_m2 >> 1);
	assign lc_full  = (lc_q == CNT_W'(MAX_SYMBOLS));
	assign w_sum    = w_rd0 + w_rd1;
	assign stk_node = stk_rd[STACK_W-1 -: NODE_AW];
	assign nl       = (e_len_q < LEN_W'(MAX_CODE_LEN)) ? e_len_q + LEN_W'(1) : e_len_q;
	assign c0       = (e_len_q < LEN_W'(MAX_CODE_LEN)) ? {e_code_q[CODE_W-2:0], 1'b0}
		: e_code_q;
	assign c1       = (e_len_q < LEN_W'(MAX_CODE_LEN)) ? {e_code_q[CODE_W-2:0], 1'b1}
		: e_code_q;

	always_comb begin
		leaf_we  = 1'b0;
		leaf_wa  = '0;
		leaf_wd  = sym_q;
		leaf_ra  = stk_node[SLOT_AW-1:0];
		wt_we    = 1'b0;
		wt_wa    = nxt_q;
		wt_wd    = w_sum;
		wt_ra0   = heap_rd0;
		wt_ra1   = heap_rd1;
		ch_we    = 1'b0;
		ch_wa    = nxt_q;
		ch_wd    = {a_q, b_q};
		ch_ra    = stk_node;
		heap_we  = 1'b0;
		heap_wa  = i_q;
		heap_wd  = node_i_q;
		heap_ra0 = '0;
		heap_ra1 = '0;
		code_we  = 1'b0;
		code_wa  = leaf_rd;
		code_wd  = {e_len_q, e_code_q};
		code_ra  = sym_q;
		stk_we   = 1'b0;
		stk_wa   = sp_q;
		stk_wd   = {lchild_q, nl, c0};
		stk_ra   = sp_q - STACK_AW'(1);
		unique case (state_q)
			S_EXEC: begin
				if (func_q == FUNC_LOAD && !lc_full) begin
					leaf_we = 1'b1;
					leaf_wa = SLOT_AW'(lc_q);
					wt_we   = 1'b1;
					wt_wa   = NODE_AW'(lc_q);
					wt_wd   = WGT_W'(freq_q);
				end
			end
			S_FILL: begin
				heap_we = 1'b1;
				heap_wd = NODE_AW'(i_q);
			end
			S_HP0: heap_ra0 = hi_q;
			S_SDR: begin
				heap_ra0 = l_idx[SLOT_AW-1:0];
				heap_ra1 = r_idx[SLOT_AW-1:0];
			end
			S_SDM: begin
				heap_we = 1'b1;
				heap_wd = sd_move ? sd_node : node_i_q;
			end
			S_TK0: heap_ra1 = hs_m1[SLOT_AW-1:0];
			S_TK1: wt_ra0 = heap_rd1;
			S_MG0: begin
				wt_ra0 = a_q;
				wt_ra1 = b_q;
			end
			S_MG1: begin
				wt_we = 1'b1;
				ch_we = 1'b1;
			end
			S_PU0: begin
				if (i_q == '0) begin
					heap_we = 1'b1;
					heap_wd = nxt_q;
				end else begin
					heap_ra0 = parent;
				end
			end
			S_PU2: begin
				heap_we = 1'b1;
				heap_wd = (wn_q < w_rd0) ? ps_q : nxt_q;
			end
			S_RT1: begin
				stk_we = 1'b1;
				stk_wa = '0;
				stk_wd = {heap_rd0, LEN_W'(0), CODE_W'(0)};
			end
			S_W2: code_we = 1'b1;
			S_W3: begin
				stk_we = 1'b1;
				stk_wd = {ch_rd[NODE_AW-1:0], nl, c1};
			end
			S_W4: stk_we = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
			lc_q     <= '0;
			tr_q     <= 1'b0;
			valid_q  <= '0;
		end else begin
			if (ovalid_q && rsp.ready && state_q != S_RESP) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						func_q  <= func_t'(cmd.func);
						sym_q   <= cmd.symbol;
						freq_q  <= cmd.frequency;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_stat_q <= ST_OK;
					res_word_q <= '0;
					res_len_q  <= '0;
					state_q    <= S_RESP;
					unique case (func_q)
						FUNC_LOAD: begin
							if (lc_full) begin
								res_stat_q <= ST_FULL;
							end else begin
								lc_q <= lc_q + CNT_W'(1);
								tr_q <= 1'b0;
							end
						end
						FUNC_BUILD: begin
							if (lc_q == '0) begin
								res_stat_q <= ST_EMPTY;
							end else begin
								valid_q <= '0;
								i_q     <= '0;
								state_q <= S_FILL;
							end
						end
						FUNC_LOOKUP: begin
							if (!tr_q) begin
								res_stat_q <= ST_NOT_READY;
							end else begin
								state_q <= S_LKW;
							end
						end
						FUNC_CLEAR: begin
							lc_q    <= '0;
							tr_q    <= 1'b0;
							valid_q <= '0;
						end
						default: begin
						end
					endcase
				end
				S_LKW: begin
					if (valid_q[sym_q]) begin
						res_word_q <= code_rd[CODE_W-1:0];
						res_len_q  <= code_rd[CTAB_W-1:CODE_W];
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!ovalid_q || rsp.ready) begin
						ovalid_q <= 1'b1;
						ostat_q  <= res_stat_q;
						oword_q  <= res_word_q;
						olen_q   <= res_len_q;
						state_q  <= S_IDLE;
					end
				end
				S_FILL: begin
					i_q <= i_q + SLOT_AW'(1);
					if (CNT_W'(i_q) == lc_q - CNT_W'(1)) begin
						hs_q  <= lc_q;
						nxt_q <= NODE_AW'(lc_q);
						if (lc_q >= CNT_W'(2)) begin
							hi_q    <= hi_start;
							state_q <= S_HP0;
						end else begin
							state_q <= S_MCHK;
						end
					end
				end
				S_HP0: state_q <= S_HP1;
				S_HP1: begin
					node_i_q <= heap_rd0;
					i_q      <= hi_q;
					ret_q    <= RET_HPY;
					state_q  <= S_SDW;
				end
				S_SDW: begin
					wi_q    <= w_rd0;
					state_q <= S_SDR;
				end
				S_SDR: state_q <= S_SDC;
				S_SDC: begin
					sl_q    <= heap_rd0;
					sr_q    <= heap_rd1;
					state_q <= S_SDM;
				end
				S_SDM: begin
					if (sd_move) begin
						i_q     <= sd_dst;
						state_q <= S_SDR;
					end else begin
						case (ret_q)
							RET_HPY: begin
								if (hi_q == '0) begin
									state_q <= S_MCHK;
								end else begin
									hi_q    <= hi_q - SLOT_AW'(1);
									state_q <= S_HP0;
								end
							end
							RET_TA: begin
								take_b_q <= 1'b1;
								state_q  <= S_TK0;
							end
							default: state_q <= S_MG0;
						endcase
					end
				end
				S_MCHK: begin
					if (hs_q > CNT_W'(1)) begin
						take_b_q <= 1'b0;
						state_q  <= S_TK0;
					end else begin
						state_q <= S_RT0;
					end
				end
				S_TK0: state_q <= S_TK1;
				S_TK1: begin
					if (take_b_q) begin
						b_q   <= heap_rd0;
						ret_q <= RET_TB;
					end else begin
						a_q   <= heap_rd0;
						ret_q <= RET_TA;
					end
					node_i_q <= heap_rd1;
					hs_q     <= hs_m1;
					i_q      <= '0;
					state_q  <= S_SDW;
				end
				S_MG0: state_q <= S_MG1;
				S_MG1: begin
					wn_q    <= w_sum;
					hs_q    <= hs_q + CNT_W'(1);
					i_q     <= SLOT_AW'(hs_q);
					state_q <= S_PU0;
				end
				S_PU0: begin
					if (i_q == '0) begin
						nxt_q   <= nxt_q + NODE_AW'(1);
						state_q <= S_MCHK;
					end else begin
						state_q <= S_PU1;
					end
				end
				S_PU1: begin
					ps_q    <= heap_rd0;
					state_q <= S_PU2;
				end
				S_PU2: begin
					if (wn_q < w_rd0) begin
						i_q     <= parent;
						state_q <= S_PU0;
					end else begin
						nxt_q   <= nxt_q + NODE_AW'(1);
						state_q <= S_MCHK;
					end
				end
				S_RT0: state_q <= S_RT1;
				S_RT1: begin
					sp_q    <= STACK_AW'(1);
					state_q <= S_W0;
				end
				S_W0: begin
					if (sp_q == '0) begin
						tr_q    <= 1'b1;
						state_q <= S_RESP;
					end else begin
						sp_q    <= sp_q - STACK_AW'(1);
						state_q <= S_W1;
					end
				end
				S_W1: begin
					e_len_q  <= stk_rd[CODE_W +: LEN_W];
					e_code_q <= stk_rd[CODE_W-1:0];
					state_q  <= (stk_node < NODE_AW'(lc_q)) ? S_W2 : S_W3;
				end
				S_W2: begin
					valid_q[leaf_rd] <= 1'b1;
					state_q          <= S_W0;
				end
				S_W3: begin
					lchild_q <= ch_rd[2*NODE_AW-1:NODE_AW];
					sp_q     <= sp_q + STACK_AW'(1);
					state_q  <= S_W4;
				end
				S_W4: begin
					sp_q    <= sp_q + STACK_AW'(1);
					state_q <= S_W0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	hcb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(SYM_W)) u_leaf (
		.clk(clk), .we(leaf_we), .waddr(leaf_wa), .wdata(leaf_wd),
		.raddr(leaf_ra), .rdata(leaf_rd)
	);

	hcb_ram2r #(.DEPTH(NODE_DEPTH), .WIDTH(WGT_W)) u_weight (
		.clk(clk), .we(wt_we), .waddr(wt_wa), .wdata(wt_wd),
		.raddr0(wt_ra0), .rdata0(w_rd0), .raddr1(wt_ra1), .rdata1(w_rd1)
	);

	hcb_ram #(.DEPTH(NODE_DEPTH), .WIDTH(2*NODE_AW)) u_children (
		.clk(clk), .we(ch_we), .waddr(ch_wa), .wdata(ch_wd),
		.raddr(ch_ra), .rdata(ch_rd)
	);

	hcb_ram2r #(.DEPTH(MAX_SYMBOLS), .WIDTH(NODE_AW)) u_heap (
		.clk(clk), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
		.raddr0(heap_ra0), .rdata0(heap_rd0), .raddr1(heap_ra1), .rdata1(heap_rd1)
	);

	hcb_ram #(.DEPTH(SYM_COUNT), .WIDTH(CTAB_W)) u_code (
		.clk(clk), .we(code_we), .waddr(code_wa), .wdata(code_wd),
		.raddr(code_ra), .rdata(code_rd)
	);

	hcb_ram #(.DEPTH(STACK_DEPTH), .WIDTH(STACK_W)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
		.raddr(stk_ra), .rdata(stk_rd)
	);
endmodule

FILE: rtl/hcb_ram.sv
// ----------------------------------------------------------------------------
// hcb_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module hcb_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/hcb_ram2r.sv
// ----------------------------------------------------------------------------
// hcb_ram2r
// single write port, two registered read ports memory
// ----------------------------------------------------------------------------
module hcb_ram2r #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	output logic [WIDTH-1:0]         rdata0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata1
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end
endmodule

FILE: rtl/hcb_checker.sv
// ----------------------------------------------------------------------------
// hcb_checker
// port-level checks of the huffman code builder, bound to the top level
// ----------------------------------------------------------------------------
`include "huffman_code_builder_macros.svh"

module hcb_checker import hcb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [STAT_W-1:0] status,
	input logic [CODE_W-1:0] code_word,
	input logic [LEN_W-1:0]  code_len
);
	`HCB_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(code_word) && $stable(code_len), "response word changed while stalled")
	`HCB_ASSERT_NEXT(a_one_cmd, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready, "command taken while busy")
	`HCB_ASSERT_NOW(a_len_max, clk, arst_n, rsp_valid, code_len <= LEN_W'(MAX_CODE_LEN), "code length too long")
	`HCB_ASSERT_NOW(a_word_fit, clk, arst_n, rsp_valid, (code_word >> code_len) == '0, "code word wider than its length")
	`HCB_ASSERT_NOW(a_err_zero, clk, arst_n, rsp_valid && status != ST_OK, code_len == '0 && code_word == '0, "error word carries a code")
endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd.valid),
	.cmd_ready(cmd.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status(rsp.status),
	.code_word(rsp.code_word),
	.code_len(rsp.code_len)
);
